// ===== sv/srr_pkg.sv =====
`default_nettype none
package srr_pkg;

	localparam int unsigned WIN_W       = 4;
	localparam int unsigned RESET_WIN   = 10;
	localparam int unsigned MAX_RELEASE = 10;
	localparam int unsigned CNT_W       = 4;

	typedef enum logic {
		KIND_DELIVER = 1'b0,
		KIND_ACK     = 1'b1
	} kind_t;

	typedef enum logic {
		ALU_INC,
		ALU_DIST
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COUNT,
		ST_READ,
		ST_DELIV,
		ST_WAIT_D,
		ST_ACK,
		ST_WAIT_A
	} state_t;

endpackage
`default_nettype wire

// ===== sv/srr_ifs.sv =====
`default_nettype none
interface srr_in_if #(
	parameter int unsigned SEQ_W        = 5,
	parameter int unsigned PAYLOAD_BITS = 32
);
	logic                    valid;
	logic                    ready;
	logic [SEQ_W-1:0]        seq_number;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, seq_number, payload, input ready);
	modport sink   (input valid, seq_number, payload, output ready);
endinterface

interface srr_out_if #(
	parameter int unsigned SEQ_W        = 5,
	parameter int unsigned PAYLOAD_BITS = 32
);
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [SEQ_W-1:0]        ack_number;
	logic [SEQ_W-1:0]        expected_seq;
	logic                    last;

	modport source (output valid, kind, out_payload, ack_number, expected_seq, last,
		input ready);
	modport sink   (input valid, kind, out_payload, ack_number, expected_seq, last,
		output ready);
endinterface
`default_nettype wire

// ===== sv/srr_ring_alu.sv =====
`default_nettype none
// modular step and window distance on slot indices
module srr_ring_alu #(
	parameter int unsigned SEQ_COUNT = 20
) (
	input  wire srr_pkg::alu_op_t           op,
	input  wire [$clog2(SEQ_COUNT)-1:0]     a,
	input  wire [$clog2(SEQ_COUNT)-1:0]     b,
	output logic [$clog2(SEQ_COUNT)-1:0]    y
);
	import srr_pkg::*;

	localparam int unsigned IDX_W = $clog2(SEQ_COUNT);

	logic [IDX_W:0] wrap_sum;

	always_comb begin
		wrap_sum = {1'b0, a} + (IDX_W+1)'(SEQ_COUNT) - {1'b0, b};
		unique case (op)
			ALU_INC: begin
				y = (a == IDX_W'(SEQ_COUNT - 1)) ? '0 : a + IDX_W'(1);
			end
			ALU_DIST: begin
				y = (a >= b) ? a - b : wrap_sum[IDX_W-1:0];
			end
			default: begin
				y = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/srr_slot_mem.sv =====
`default_nettype none
module srr_slot_mem #(
	parameter int unsigned SEQ_COUNT    = 20,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  wire                           clk,
	input  wire                           we,
	input  wire [$clog2(SEQ_COUNT)-1:0]   waddr,
	input  wire [PAYLOAD_BITS-1:0]        wdata,
	input  wire [$clog2(SEQ_COUNT)-1:0]   raddr,
	output logic [PAYLOAD_BITS-1:0]       rdata
);
	logic [PAYLOAD_BITS-1:0] mem [SEQ_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/selective_repeat_receiver_top.sv =====
// Acknowledgement path when nothing is released: CHECK, then ACK, then WAIT_A shows the acknowledgement.
// With n released slots: run counting in COUNT, then each delivery in READ, DELIV and WAIT_D
// (memory read, load, handshake) and the acknowledgement after them.
// One request at a time: a new request is taken only once the block is back in idle.
// Reset (arst_n low, asynchronous): window 10, all slots empty, expected sequence number 1 (slot 0), idle.
`default_nettype none
module selective_repeat_receiver_top #(
	parameter int unsigned SEQ_COUNT    = 20,
	parameter int unsigned PAYLOAD_BITS = 32
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [srr_pkg::WIN_W-1:0] cfg_wdata,
	srr_in_if.sink                   in_ch,
	srr_out_if.source                out_ch
);
	import srr_pkg::*;

	localparam int unsigned IDX_W   = $clog2(SEQ_COUNT);
	localparam int unsigned SEQ_W   = $clog2(SEQ_COUNT + 1);
	localparam int unsigned HALF    = SEQ_COUNT / 2;
	localparam int unsigned WIN_CAP = (HALF < MAX_RELEASE) ? HALF : MAX_RELEASE;
	localparam int unsigned CMP_W   = 8;

	state_t                  state_q, state_d;
	logic [WIN_W-1:0]        window_q;
	logic [SEQ_COUNT-1:0]    filled_q;
	logic [IDX_W-1:0]        ne_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        rem_q;
	logic [SEQ_W-1:0]        seq_q;
	logic [PAYLOAD_BITS-1:0] data_q;
	kind_t                   kind_q;
	logic [PAYLOAD_BITS-1:0] opay_q;
	logic                    last_q;

	alu_op_t                 alu_op;
	logic [IDX_W-1:0]        alu_a;
	logic [IDX_W-1:0]        alu_b;
	logic [IDX_W-1:0]        alu_y;

	logic                    in_range;
	logic [IDX_W-1:0]        slot;
	logic [CMP_W-1:0]        win_eff;
	logic                    in_win;
	logic                    hit;
	logic                    mem_we;
	logic [PAYLOAD_BITS-1:0] mem_rdata;
	logic                    run_more;
	logic                    in_take;
	logic                    out_take;
	logic [SEQ_W:0]          exp_one;

	srr_ring_alu #(.SEQ_COUNT(SEQ_COUNT)) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	srr_slot_mem #(.SEQ_COUNT(SEQ_COUNT), .PAYLOAD_BITS(PAYLOAD_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot),
		.wdata (data_q),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	always_comb begin
		in_range = (seq_q != '0) && ({1'b0, seq_q} <= (SEQ_W+1)'(SEQ_COUNT));
		slot     = IDX_W'(seq_q - SEQ_W'(1));
		win_eff  = ({{(CMP_W-WIN_W){1'b0}}, window_q} > CMP_W'(WIN_CAP)) ?
			CMP_W'(WIN_CAP) : {{(CMP_W-WIN_W){1'b0}}, window_q};
		in_win   = in_range && ({{(CMP_W-IDX_W){1'b0}}, alu_y} < win_eff);
		hit      = in_win && (slot == ne_q);
		run_more = (cnt_q < CNT_W'(MAX_RELEASE)) && filled_q[ptr_q];
		in_take  = in_ch.valid && in_ch.ready;
		out_take = out_ch.valid && out_ch.ready;
		exp_one  = {{(SEQ_W+1-IDX_W){1'b0}}, ne_q} + (SEQ_W+1)'(1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_take) state_d = ST_CHECK;
			ST_CHECK:  state_d = hit ? ST_COUNT : ST_ACK;
			ST_COUNT:  if (!run_more) state_d = ST_READ;
			ST_READ:   state_d = ST_DELIV;
			ST_DELIV:  state_d = ST_WAIT_D;
			ST_WAIT_D: if (out_take) state_d = (rem_q == '0) ? ST_ACK : ST_READ;
			ST_ACK:    state_d = ST_WAIT_A;
			ST_WAIT_A: if (out_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		alu_op      = ALU_INC;
		alu_a       = ptr_q;
		alu_b       = ne_q;
		mem_we      = 1'b0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
			end
			ST_CHECK: begin
				alu_op = ALU_DIST;
				alu_a  = slot;
				mem_we = in_win && !filled_q[slot];
			end
			default: begin
			end
		endcase
	end

	assign out_ch.valid        = (state_q == ST_WAIT_D) || (state_q == ST_WAIT_A);
	assign out_ch.kind         = kind_q;
	assign out_ch.out_payload  = opay_q;
	assign out_ch.ack_number   = seq_q;
	assign out_ch.expected_seq = exp_one[SEQ_W-1:0];
	assign out_ch.last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			window_q <= WIN_W'(RESET_WIN);
			filled_q <= '0;
			ne_q     <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			rem_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CHECK: begin
					if (mem_we) begin
						filled_q[slot] <= 1'b1;
					end
					ptr_q <= ne_q;
					cnt_q <= '0;
				end
				ST_COUNT: begin
					if (run_more) begin
						cnt_q <= cnt_q + CNT_W'(1);
						ptr_q <= alu_y;
					end else begin
						ne_q  <= ptr_q;
						ptr_q <= ne_q;
						rem_q <= cnt_q;
					end
				end
				ST_DELIV: begin
					filled_q[ptr_q] <= 1'b0;
					ptr_q           <= alu_y;
					rem_q           <= rem_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			seq_q  <= in_ch.seq_number;
			data_q <= in_ch.payload;
		end
		if (state_q == ST_DELIV) begin
			kind_q <= KIND_DELIVER;
			opay_q <= mem_rdata;
			last_q <= 1'b0;
		end else if (state_q == ST_ACK) begin
			kind_q <= KIND_ACK;
			opay_q <= '0;
			last_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== sv/srr_checker.sv =====
`default_nettype none
module srr_checker #(
	parameter int unsigned PAYLOAD_BITS = 32,
	parameter int unsigned SEQ_W        = 5
) (
	input wire                    clk,
	input wire                    arst_n,
	input wire                    in_valid,
	input wire                    in_ready,
	input wire                    out_valid,
	input wire                    out_ready,
	input wire                    kind,
	input wire [PAYLOAD_BITS-1:0] out_payload,
	input wire [SEQ_W-1:0]        expected_seq,
	input wire                    last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload) && $stable(last))
		else $error("stalled result changed");

	// one request in flight: no new request while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready straight after request");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == last))
		else $error("kind and last disagree");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready && $stable(expected_seq))
		else $error("step ended before acknowledgement");

endmodule

bind selective_repeat_receiver_top srr_checker #(
	.PAYLOAD_BITS (PAYLOAD_BITS),
	.SEQ_W        ($clog2(SEQ_COUNT + 1))
) u_srr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.kind         (out_ch.kind),
	.out_payload  (out_ch.out_payload),
	.expected_seq (out_ch.expected_seq),
	.last         (out_ch.last)
);
`default_nettype wire
